// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in the same cycle.
`define PLC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define PLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/plc_pkg.sv =====
package plc_pkg;

    // Lock modes as they appear on the mode output.
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_NEED_LEN  = 3'd1,
        MODE_ENTERING  = 3'd2,
        MODE_LOCKED    = 3'd3,
        MODE_UNLOCKING = 3'd4,
        MODE_UNLOCKED  = 3'd5,
        MODE_WAITING   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        MENU_NONE     = 2'd0,
        MENU_IDLE     = 2'd1,
        MENU_LOCKED   = 2'd2,
        MENU_UNLOCKED = 2'd3
    } menu_t;

    // Event kinds on the operation input.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_TIMER = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BLINK_COUNT  = 2'd0;
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd1;
    localparam logic [1:0] REG_ACCEPT_DELAY = 2'd2;

    localparam logic [3:0] BLINK_COUNT_RST  = 4'd6;
    localparam logic [7:0] BLINK_PERIOD_RST = 8'h64;
    localparam logic [7:0] ACCEPT_DELAY_RST = 8'd205;

    // Command characters.
    localparam logic [7:0] CHAR_S_UP = 8'h53;
    localparam logic [7:0] CHAR_S_LO = 8'h73;
    localparam logic [7:0] CHAR_U_UP = 8'h55;
    localparam logic [7:0] CHAR_U_LO = 8'h75;
    localparam logic [7:0] CHAR_R_UP = 8'h52;
    localparam logic [7:0] CHAR_R_LO = 8'h72;
    localparam logic [7:0] CHAR_L_UP = 8'h4C;
    localparam logic [7:0] CHAR_L_LO = 8'h6C;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef struct packed {
        logic [3:0] blink_count;
        logic [7:0] blink_period;
        logic [7:0] accept_delay;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] led_mask;
        logic       timer_start;
        logic [7:0] timer_load;
        menu_t      menu;
    } result_t;

    // Lights the n low LEDs; eight or more light all of them.
    function automatic logic [7:0] fill_mask(input logic [3:0] n);
        logic [7:0] m;
        m = 8'hFF;
        if (n < 4'd8)
        begin
            m = 8'((9'd1 << n) - 9'd1);
        end
        return m;
    endfunction

endpackage

// ===== sv/plc_cfg.sv =====
module plc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output plc_pkg::cfg_t       cfg
);

    plc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_count  <= plc_pkg::BLINK_COUNT_RST;
            cfg_reg.blink_period <= plc_pkg::BLINK_PERIOD_RST;
            cfg_reg.accept_delay <= plc_pkg::ACCEPT_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                plc_pkg::REG_BLINK_COUNT:  cfg_reg.blink_count  <= pwdata[3:0];
                plc_pkg::REG_BLINK_PERIOD: cfg_reg.blink_period <= pwdata[7:0];
                plc_pkg::REG_ACCEPT_DELAY: cfg_reg.accept_delay <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            plc_pkg::REG_BLINK_COUNT:  prdata = {28'd0, cfg_reg.blink_count};
            plc_pkg::REG_BLINK_PERIOD: prdata = {24'd0, cfg_reg.blink_period};
            plc_pkg::REG_ACCEPT_DELAY: prdata = {24'd0, cfg_reg.accept_delay};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/plc_core.sv =====
module plc_core #(
    parameter int MAX_SECRET_LEN = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             operation,
    input  logic [7:0]       rx_byte,
    input  plc_pkg::cfg_t    cfg,
    output plc_pkg::result_t result
);

    localparam int         IDX_W    = (MAX_SECRET_LEN > 1) ? $clog2(MAX_SECRET_LEN) : 1;
    localparam logic [3:0] MAX_LEN  = 4'(MAX_SECRET_LEN);
    localparam logic [7:0] LEN_LAST = 8'(48 + MAX_SECRET_LEN);

    plc_pkg::mode_t mode_reg, mode_next;
    logic [3:0]     secret_length_reg, secret_length_next;
    logic [3:0]     position_reg, position_next;
    logic           mismatch_seen_reg, mismatch_seen_next;
    logic           was_accepted_reg, was_accepted_next;
    logic [3:0]     blink_counter_reg, blink_counter_next;
    logic [7:0]     led_value_reg, led_value_next;
    logic [7:0]     secret_reg [MAX_SECRET_LEN];

    logic           is_byte, is_timer;
    logic           is_s, is_u, is_r, is_l, len_ok;
    logic [3:0]     pos_inc, blink_inc;
    logic           entry_done, pos_in_range, mismatch_now, blink_more;
    logic [7:0]     secret_rd;
    logic           secret_we;
    logic           tstart;
    logic [7:0]     tload;
    plc_pkg::menu_t menu;

    assign is_byte  = (operation == plc_pkg::OP_BYTE);
    assign is_timer = (operation == plc_pkg::OP_TIMER);
    assign is_s     = (rx_byte == plc_pkg::CHAR_S_UP) || (rx_byte == plc_pkg::CHAR_S_LO);
    assign is_u     = (rx_byte == plc_pkg::CHAR_U_UP) || (rx_byte == plc_pkg::CHAR_U_LO);
    assign is_r     = (rx_byte == plc_pkg::CHAR_R_UP) || (rx_byte == plc_pkg::CHAR_R_LO);
    assign is_l     = (rx_byte == plc_pkg::CHAR_L_UP) || (rx_byte == plc_pkg::CHAR_L_LO);
    assign len_ok   = (rx_byte >= plc_pkg::CHAR_ONE) && (rx_byte <= LEN_LAST);

    assign pos_inc      = position_reg + 4'd1;
    assign entry_done   = (pos_inc >= secret_length_reg);
    assign pos_in_range = (position_reg < MAX_LEN);
    assign secret_rd    = pos_in_range ? secret_reg[position_reg[IDX_W-1:0]] : 8'd0;
    assign mismatch_now = mismatch_seen_reg || (secret_rd != rx_byte);
    assign blink_inc    = blink_counter_reg + 4'd1;
    assign blink_more   = (blink_inc < cfg.blink_count);

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (is_byte)
        begin
            unique case (mode_reg)
                plc_pkg::MODE_IDLE:
                    if (is_s) mode_next = plc_pkg::MODE_NEED_LEN;
                plc_pkg::MODE_NEED_LEN:
                    if (len_ok) mode_next = plc_pkg::MODE_ENTERING;
                plc_pkg::MODE_ENTERING:
                    if (entry_done) mode_next = plc_pkg::MODE_UNLOCKED;
                plc_pkg::MODE_LOCKED:
                    if (is_u) mode_next = plc_pkg::MODE_UNLOCKING;
                plc_pkg::MODE_UNLOCKING:
                    if (entry_done) mode_next = plc_pkg::MODE_WAITING;
                plc_pkg::MODE_UNLOCKED:
                    if (is_r)
                    begin
                        mode_next = plc_pkg::MODE_IDLE;
                    end
                    else if (is_l)
                    begin
                        mode_next = plc_pkg::MODE_LOCKED;
                    end
                default: ;
            endcase
        end
        else if (mode_reg == plc_pkg::MODE_WAITING)
        begin
            if (was_accepted_reg)
            begin
                mode_next = plc_pkg::MODE_UNLOCKED;
            end
            else if (!blink_more)
            begin
                mode_next = plc_pkg::MODE_LOCKED;
            end
        end
    end

    // Datapath registers and result fields.
    always_comb
    begin
        secret_length_next = secret_length_reg;
        position_next      = position_reg;
        mismatch_seen_next = mismatch_seen_reg;
        was_accepted_next  = was_accepted_reg;
        blink_counter_next = blink_counter_reg;
        led_value_next     = led_value_reg;
        secret_we          = 1'b0;
        tstart             = 1'b0;
        tload              = 8'd0;
        menu               = plc_pkg::MENU_NONE;
        if (is_byte)
        begin
            unique case (mode_reg)
                plc_pkg::MODE_NEED_LEN:
                    if (len_ok)
                    begin
                        // The digits '1' to '9' carry their value in the low nibble.
                        secret_length_next = rx_byte[3:0];
                        position_next      = 4'd0;
                    end
                plc_pkg::MODE_ENTERING:
                begin
                    secret_we     = pos_in_range;
                    position_next = pos_inc;
                    if (entry_done) menu = plc_pkg::MENU_UNLOCKED;
                end
                plc_pkg::MODE_LOCKED:
                    if (is_u)
                    begin
                        position_next      = 4'd0;
                        mismatch_seen_next = 1'b0;
                    end
                plc_pkg::MODE_UNLOCKING:
                begin
                    mismatch_seen_next = mismatch_now;
                    position_next      = pos_inc;
                    led_value_next     = plc_pkg::fill_mask(pos_inc);
                    if (entry_done)
                    begin
                        tstart = 1'b1;
                        if (mismatch_now)
                        begin
                            was_accepted_next  = 1'b0;
                            blink_counter_next = 4'd0;
                            led_value_next     = 8'd0;
                            tload              = cfg.blink_period;
                        end
                        else
                        begin
                            was_accepted_next = 1'b1;
                            tload             = cfg.accept_delay;
                        end
                    end
                end
                plc_pkg::MODE_UNLOCKED:
                    if (is_r)
                    begin
                        menu = plc_pkg::MENU_IDLE;
                    end
                    else if (is_l)
                    begin
                        menu = plc_pkg::MENU_LOCKED;
                    end
                default: ;
            endcase
        end
        else if (is_timer && (mode_reg == plc_pkg::MODE_WAITING))
        begin
            if (was_accepted_reg)
            begin
                led_value_next = 8'd0;
                menu           = plc_pkg::MENU_UNLOCKED;
            end
            else
            begin
                blink_counter_next = blink_inc;
                led_value_next     = blink_inc[0] ? plc_pkg::fill_mask(secret_length_reg)
                                                  : 8'd0;
                if (blink_more)
                begin
                    tstart = 1'b1;
                    tload  = cfg.blink_period;
                end
                else
                begin
                    menu = plc_pkg::MENU_LOCKED;
                end
            end
        end
    end

    assign result.mode        = mode_next;
    assign result.led_mask    = led_value_next;
    assign result.timer_start = tstart;
    assign result.timer_load  = tload;
    assign result.menu        = menu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= plc_pkg::MODE_IDLE;
            secret_length_reg <= 4'd0;
            position_reg      <= 4'd0;
            mismatch_seen_reg <= 1'b0;
            was_accepted_reg  <= 1'b0;
            blink_counter_reg <= 4'd0;
            led_value_reg     <= 8'd0;
        end
        else if (step_en)
        begin
            mode_reg          <= mode_next;
            secret_length_reg <= secret_length_next;
            position_reg      <= position_next;
            mismatch_seen_reg <= mismatch_seen_next;
            was_accepted_reg  <= was_accepted_next;
            blink_counter_reg <= blink_counter_next;
            led_value_reg     <= led_value_next;
        end
    end

    // Secret storage has no reset; every entry is written before it is compared.
    always_ff @(posedge clk)
    begin
        if (step_en && secret_we)
        begin
            secret_reg[position_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

// ===== sv/password_lock_controller.sv =====
// Password lock controller. Each input item is either a received serial byte
// (operation 0) or the expiry of the external period timer (operation 1), and
// each item yields exactly one result item with the mode after the event, the
// LED mask, a timer start request with its load value and a menu request.
// 'S' followed by a digit from 1 to MAX_SECRET_LEN and that many bytes stores
// the password and opens the lock; when open, 'L' locks and 'R' returns to
// idle; when locked, 'U' followed by the stored number of bytes tries to
// unlock, and the LEDs count the entered bytes. A correct entry asks for a
// timer run of accept_delay and opens on the next expiry; a wrong one blinks
// the mask for blink_count periods of blink_period and then relocks. Bytes
// that mean nothing in the current mode, and expiries outside the waiting
// mode, leave the state alone and return the current mode and LEDs.
// Flow: an accepted item is held in an input register, processed by the state
// logic once the output register can take its result, and its result is
// captured in the output register, from which it is offered on out_valid.
// One item is accepted every cycle as long as out_stall stays low; the only
// limit on throughput is the single output register, which stalls the input
// side while a result waits to be taken and another item is already held.
// Configuration registers sit on a small APB port at byte addresses 0, 4
// and 8 and should be written only while no item is in flight.
module password_lock_controller #(
    parameter int MAX_SECRET_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input item channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    // Result item channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  mode,
    output logic [7:0]  led_mask,
    output logic        timer_start,
    output logic [7:0]  timer_load,
    output logic [1:0]  menu_request
);

`include "assert_macros.svh"

    plc_pkg::cfg_t    cfg;
    plc_pkg::result_t step_result;
    plc_pkg::result_t result_reg;

    logic       in_full_reg;
    logic       op_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;
    logic       in_take;

    plc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The output register is free when empty or when its result leaves now.
    // A held item is processed whenever the output register can take its result.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= operation;
            byte_reg <= rx_byte;
        end
    end

    plc_core #(
        .MAX_SECRET_LEN (MAX_SECRET_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .operation (op_reg),
        .rx_byte   (byte_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mode         = 3'(result_reg.mode);
    assign led_mask     = result_reg.led_mask;
    assign timer_start  = result_reg.timer_start;
    assign timer_load   = result_reg.timer_load;
    assign menu_request = 2'(result_reg.menu);

    // A timer load value is only ever presented together with a start request.
    `PLC_ASSERT(a_load_needs_start, !out_valid || timer_start || (timer_load == 8'd0), "timer load without start")

    // The timer is started only on the way into, or while staying in, the waiting mode.
    `PLC_ASSERT(a_start_in_waiting, !(out_valid && timer_start) || (mode == plc_pkg::MODE_WAITING), "timer start outside waiting")

    // A locked menu request always comes with the locked mode.
    `PLC_ASSERT(a_menu_locked, !(out_valid && (menu_request == plc_pkg::MENU_LOCKED)) || (mode == plc_pkg::MODE_LOCKED), "locked menu in wrong mode")

    // An accepted item is held until the core takes it.
    `PLC_ASSERT_NEXT(a_item_held, in_valid && !in_stall, in_full_reg, "accepted item not held")

endmodule
